// ----- design/sbph_pkg.sv -----
package sbph_pkg;

  // Field widths of the channels.
  localparam int BAR_W   = 6;
  localparam int MAG_W   = 16;
  localparam int X_W     = 9;
  localparam int Y_W     = 6;
  localparam int COLOR_W = 8;

  // Reset value of the full scale register.
  localparam logic [MAG_W-1:0] FULL_SCALE_RESET = 16'd10000;

  // Result kinds.
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_PEAK = 1'b1;

  typedef logic [BAR_W-1:0]   bar_t;
  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [X_W-1:0]     x_t;
  typedef logic [Y_W-1:0]     y_t;
  typedef logic [COLOR_W-1:0] color_t;

  // One bar ready for drawing: columns, lit level count and peak row.
  typedef struct packed {
    x_t x_left;
    x_t x_right;
    y_t height;
    y_t peak;
  } sbph_job_t;

endpackage

// ----- design/sbph_if.sv -----
// Input channel: one bar per item.
interface sbph_in_if import sbph_pkg::*; ();
  logic valid;
  logic ready;
  bar_t bar_index;
  mag_t magnitude;

  modport source(output valid, bar_index, magnitude, input ready);
  modport sink(input valid, bar_index, magnitude, output ready);
endinterface

// Output channel: one rectangle per item.
interface sbph_out_if import sbph_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   item_kind;
  x_t     x_left;
  x_t     x_right;
  y_t     y_top;
  y_t     y_bottom;
  color_t red;
  color_t green;
  color_t blue;
  logic   last_of_bar;

  modport source(output valid, item_kind, x_left, x_right, y_top, y_bottom, red, green,
                 blue, last_of_bar, input ready);
  modport sink(input valid, item_kind, x_left, x_right, y_top, y_bottom, red, green,
               blue, last_of_bar, output ready);
endinterface

// Configuration channel: writes the full scale register.
interface sbph_cfg_if import sbph_pkg::*; ();
  logic valid;
  logic ready;
  mag_t full_scale;

  modport source(output valid, full_scale, input ready);
  modport sink(input valid, full_scale, output ready);
endinterface

// ----- design/spectrum_bar_peak_hold_raster.sv -----
// Spectrum bar raster with peak hold. Each input item is one bar (index and
// magnitude); the block answers with one colored rectangle item per lit level,
// bottom row first, followed by a white two-row peak marker flagged with
// last_of_bar. Bars with an index at or above BAR_COUNT are taken and dropped.
// The front end takes no new bar while its bit-serial height divider is busy
// or its job waits for room in the queue; the back end emits height + 1 items
// at one item per cycle while rect_out is ready. A two-entry job queue sits
// between them. full_scale is written through the cfg channel, which is
// always ready; write it only while no bar is in flight. A full scale of zero
// acts as one.
module spectrum_bar_peak_hold_raster import sbph_pkg::*; #(
  parameter int BAR_COUNT = 35,
  parameter int HEIGHT    = 40,
  parameter int BAR_PITCH = 11
) (
  input  logic       clk,
  input  logic       rst,
  sbph_in_if.sink    bar_in,
  sbph_cfg_if.sink   cfg,
  sbph_out_if.source rect_out
);

  mag_t      full_scale;
  logic      push;
  sbph_job_t push_job;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  sbph_job_t head;

  // Configuration register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      full_scale <= cfg.full_scale;
    end
  end

  sbph_front #(
    .BAR_COUNT (BAR_COUNT),
    .HEIGHT    (HEIGHT),
    .BAR_PITCH (BAR_PITCH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bar_in     (bar_in),
    .full_scale (full_scale),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  sbph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sbph_back #(
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head),
    .pop       (pop),
    .rect_out  (rect_out)
  );

endmodule

// ----- design/sbph_ram.sv -----
module sbph_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 35
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sbph_queue.sv -----
module sbph_queue import sbph_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sbph_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output sbph_job_t head
);

  sbph_job_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job popped from an empty queue");
`endif

endmodule

// ----- design/sbph_front.sv -----
module sbph_front import sbph_pkg::*; #(
  parameter int BAR_COUNT = 35,
  parameter int HEIGHT    = 40,
  parameter int BAR_PITCH = 11
) (
  input  logic      clk,
  input  logic      rst,
  sbph_in_if.sink   bar_in,
  input  mag_t      full_scale,
  input  logic      queue_full,
  output logic      push,
  output sbph_job_t push_job
);

  localparam int AW  = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
  localparam int DW  = MAG_W + $clog2(HEIGHT + 1);
  localparam int CW  = $clog2(DW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  bar_t                 bar_q;
  logic [DW-1:0]        dq;
  logic [MAG_W-1:0]     rem;
  logic [CW-1:0]        cnt;
  logic [BAR_COUNT-1:0] pk_vld;

  logic                 accept;
  logic                 in_range;
  mag_t                 fs;
  logic [MAG_W:0]       rem_sh;
  logic                 q_bit;
  y_t                   pk_mem;
  y_t                   pk_old;
  y_t                   h;
  logic [Y_W:0]         top;
  logic [Y_W:0]         pk_inc;
  y_t                   pk_new;
  logic [10:0]          x_prod;
  x_t                   xl;

  assign bar_in.ready = (state == ST_IDLE);
  assign accept       = bar_in.valid && bar_in.ready;
  assign in_range     = ({1'b0, bar_in.bar_index} < 7'(BAR_COUNT));
  assign fs           = (full_scale == '0) ? 16'd1 : full_scale;

  // Restoring division step: one quotient bit a cycle.
  assign rem_sh = {rem, dq[DW-1]};
  assign q_bit  = (rem_sh >= {1'b0, fs});

  // Peak row per bar; an entry never written since reset reads as zero.
  sbph_ram #(.WIDTH(Y_W), .DEPTH(BAR_COUNT)) u_peak_ram (
    .clk   (clk),
    .we    (push),
    .waddr (bar_q[AW-1:0]),
    .wdata (pk_new),
    .re    (accept),
    .raddr (bar_in.bar_index[AW-1:0]),
    .rdata (pk_mem)
  );

  // Clamp the quotient to a level count and update the peak.
  always_comb begin
    if (dq > DW'(HEIGHT)) begin
      h = y_t'(HEIGHT - 1);
    end else begin
      h = dq[Y_W-1:0];
    end
    pk_old = pk_vld[bar_q[AW-1:0]] ? pk_mem : '0;
    top    = 7'(HEIGHT) - {1'b0, h};
    pk_inc = {1'b0, pk_old} + 7'd1;
    if (pk_old == '0 || top < {1'b0, pk_old}) begin
      pk_new = top[Y_W-1:0];
    end else if (pk_inc > 7'(HEIGHT - 2)) begin
      pk_new = y_t'(HEIGHT - 2);
    end else begin
      pk_new = pk_inc[Y_W-1:0];
    end
  end

  // Bar columns wrap to the column width.
  assign x_prod = 11'(bar_q) * 11'(BAR_PITCH);
  assign xl     = x_prod[X_W-1:0];

  assign push              = (state == ST_PUSH) && !queue_full;
  assign push_job.x_left   = xl;
  assign push_job.x_right  = xl + x_t'(BAR_PITCH - 2);
  assign push_job.height   = h;
  assign push_job.peak     = pk_new;

  // Sequencer: accept, divide, hand the job to the queue.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_range) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CW'(DW - 1)) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!queue_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pk_vld <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        pk_vld[bar_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      bar_q <= bar_in.bar_index;
      dq    <= DW'(bar_in.magnitude) * DW'(HEIGHT);
      rem   <= '0;
      cnt   <= '0;
    end else if (state == ST_DIV) begin
      rem <= q_bit ? 16'(rem_sh - {1'b0, fs}) : rem_sh[MAG_W-1:0];
      dq  <= {dq[DW-2:0], q_bit};
      cnt <= cnt + CW'(1);
    end
  end

endmodule

// ----- design/sbph_back.sv -----
module sbph_back import sbph_pkg::*; #(
  parameter int HEIGHT = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  sbph_job_t  job,
  output logic       pop,
  sbph_out_if.source rect_out
);

  localparam int RW = $clog2(2 * HEIGHT);
  localparam logic [9:0]    RED_Q   = 10'(510 / HEIGHT);
  localparam logic [RW-1:0] RED_R   = RW'(510 % HEIGHT);
  localparam logic [9:0]    GREEN_Q = 10'(1020 / HEIGHT);
  localparam logic [RW-1:0] GREEN_R = RW'(1020 % HEIGHT);

  // Level counter; qa/ra hold 510*y/HEIGHT, qb/rb hold 1020*y/HEIGHT.
  y_t          y;
  logic [9:0]  qa;
  logic [RW-1:0] ra;
  logic [9:0]  qb;
  logic [RW-1:0] rb;

  logic        o_valid;
  logic        o_kind;
  x_t          o_xl;
  x_t          o_xr;
  y_t          o_yt;
  y_t          o_yb;
  color_t      o_red;
  color_t      o_green;
  color_t      o_blue;
  logic        o_last;

  logic          load;
  logic          is_row;
  logic [RW-1:0] ra_sum;
  logic [RW-1:0] rb_sum;
  logic [9:0]    green_mid;
  color_t        red_c;
  color_t        green_c;

  assign load   = !o_valid || rect_out.ready;
  assign is_row = (y < job.height);
  assign pop    = load && job_valid && !is_row;

  assign ra_sum = ra + RED_R;
  assign rb_sum = rb + GREEN_R;

  // Color ramp: green to yellow, yellow to red, then solid red.
  assign green_mid = 10'd765 - qb - 10'(rb != '0);
  always_comb begin
    if ({1'b0, y, 1'b0} <= 8'(HEIGHT)) begin
      red_c   = qa[COLOR_W-1:0];
      green_c = 8'd255;
    end else if ({y, 2'b00} <= 8'(3 * HEIGHT)) begin
      red_c   = 8'd255;
      green_c = green_mid[COLOR_W-1:0];
    end else begin
      red_c   = 8'd255;
      green_c = 8'd0;
    end
  end

  // Level walk and ramp accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      y  <= '0;
      qa <= '0;
      ra <= '0;
      qb <= '0;
      rb <= '0;
    end else if (load && job_valid) begin
      if (is_row) begin
        y <= y + y_t'(1);
        if (ra_sum >= RW'(HEIGHT)) begin
          qa <= qa + RED_Q + 10'd1;
          ra <= ra_sum - RW'(HEIGHT);
        end else begin
          qa <= qa + RED_Q;
          ra <= ra_sum;
        end
        if (rb_sum >= RW'(HEIGHT)) begin
          qb <= qb + GREEN_Q + 10'd1;
          rb <= rb_sum - RW'(HEIGHT);
        end else begin
          qb <= qb + GREEN_Q;
          rb <= rb_sum;
        end
      end else begin
        y  <= '0;
        qa <= '0;
        ra <= '0;
        qb <= '0;
        rb <= '0;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= job_valid;
    end
  end

  // Output register payload: a bar row or the closing peak marker.
  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      o_xl <= job.x_left;
      o_xr <= job.x_right;
      if (is_row) begin
        o_kind  <= KIND_ROW;
        o_yt    <= y_t'(HEIGHT - 1) - y;
        o_yb    <= y_t'(HEIGHT - 1) - y;
        o_red   <= red_c;
        o_green <= green_c;
        o_blue  <= 8'd0;
        o_last  <= 1'b0;
      end else begin
        o_kind  <= KIND_PEAK;
        o_yt    <= job.peak;
        o_yb    <= job.peak + y_t'(1);
        o_red   <= 8'd255;
        o_green <= 8'd255;
        o_blue  <= 8'd255;
        o_last  <= 1'b1;
      end
    end
  end

  assign rect_out.valid       = o_valid;
  assign rect_out.item_kind   = o_kind;
  assign rect_out.x_left      = o_xl;
  assign rect_out.x_right     = o_xr;
  assign rect_out.y_top       = o_yt;
  assign rect_out.y_bottom    = o_yb;
  assign rect_out.red         = o_red;
  assign rect_out.green       = o_green;
  assign rect_out.blue        = o_blue;
  assign rect_out.last_of_bar = o_last;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (y <= job.height))
    else $error("level counter ran past the bar height");
  a_restart_level: assert property (@(posedge clk) disable iff (rst)
    pop |=> (y == '0 && qa == '0 && qb == '0))
    else $error("level walk not restarted after a peak marker");
  a_ramp_color: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind == KIND_ROW) |-> (o_red == 8'd255 || o_green == 8'd255))
    else $error("bar row color left the green-yellow-red ramp");
`endif

endmodule
